// ===== sv/cafmt_pkg.sv =====
// Shared types and constants for the cursor-addressing string formatter.
package cafmt_pkg;

  localparam int BUFFER_BYTES = 64;
  // Plain elements are dropped once the count reaches this level.
  localparam logic [8:0] CAP_LEVEL = 9'(BUFFER_BYTES - 9);

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_I    = 8'h69;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_PCT   = 2'd1,
    PH_PLUS  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,
    JOB_DEC  = 2'd1,
    JOB_MARK = 2'd2
  } job_kind_t;

  // One unit of output work: a single byte, a decimal run or an end marker.
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] value;   // byte in the low eight bits, or the number to print
    logic [2:0]  pos;     // index of the most significant digit to print
    logic        last;    // the template ends with this work
  } job_t;

endpackage

// ===== sv/cursor_address_string_formatter.sv =====
// Expands a termcap-style cursor-addressing template, one template byte per input
// transaction, into output bytes. A byte that produces at most one result is
// taken every cycle while out_stall is low; its result appears on the following
// cycle. A decimal escape (%d, %2, %3) produces one to five digit transactions,
// sent one per cycle while out_stall is low by the serialiser from its result
// register; while they drain, the input is stalled, and the next byte is taken
// in the cycle that the final digit is taken. A byte that produces nothing adds
// no output transaction and does not hold up the input. The marker transaction
// with byte_valid low appears only when the final template byte emits nothing.
module cursor_address_string_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  fmt_byte,
  input  logic        first,
  input  logic        last,
  input  logic [11:0] column,
  input  logic [11:0] row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        string_end
);

  logic            ready;
  logic            accept;
  logic            job_en;
  cafmt_pkg::job_t job;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  cafmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .fmt_byte (fmt_byte),
    .first    (first),
    .last     (last),
    .column   (column),
    .row      (row),
    .job_en   (job_en),
    .job      (job)
  );

  cafmt_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .job_en     (job_en),
    .job        (job),
    .out_stall  (out_stall),
    .ready      (ready),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

// ===== sv/cafmt_ctrl.sv =====
// Template decoder: argument, turn, escape and count state, one byte per transaction.
module cafmt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         fmt_byte,
  input  logic               first,
  input  logic               last,
  input  logic [11:0]        column,
  input  logic [11:0]        row,
  output logic               job_en,
  output cafmt_pkg::job_t    job
);

  logic [15:0]       arg_a, arg_b;
  logic              turn;
  cafmt_pkg::phase_t escape_phase;
  logic [8:0]        emitted_count;

  logic [15:0]       arg_a_next, arg_b_next;
  logic              turn_next;
  cafmt_pkg::phase_t escape_phase_next;
  logic [8:0]        emitted_count_next;

  logic [15:0]       a_eff, b_eff, cur;
  logic              t_eff;
  cafmt_pkg::phase_t p_eff;
  logic [8:0]        c_eff;
  logic              emit_byte, emit_dec;
  logic [7:0]        byte_val;
  logic [1:0]        min_w;
  logic [2:0]        n_dig, n_out;

  function automatic logic [2:0] dec_len(input logic [15:0] v);
    logic [2:0] n;
    if (v >= 16'd10000) n = 3'd5;
    else if (v >= 16'd1000) n = 3'd4;
    else if (v >= 16'd100) n = 3'd3;
    else if (v >= 16'd10) n = 3'd2;
    else n = 3'd1;
    return n;
  endfunction

  always_comb begin
    a_eff = first ? {4'd0, row} : arg_a;
    b_eff = first ? {4'd0, column} : arg_b;
    t_eff = first ? 1'b0 : turn;
    p_eff = first ? cafmt_pkg::PH_PLAIN : escape_phase;
    c_eff = first ? 9'd0 : emitted_count;
    cur   = t_eff ? b_eff : a_eff;

    arg_a_next         = a_eff;
    arg_b_next         = b_eff;
    turn_next          = t_eff;
    escape_phase_next  = p_eff;
    emitted_count_next = c_eff;
    emit_byte = 1'b0;
    emit_dec  = 1'b0;
    byte_val  = fmt_byte;
    min_w     = 2'd1;

    unique case (p_eff)
      cafmt_pkg::PH_PLAIN: begin
        if (c_eff < cafmt_pkg::CAP_LEVEL) begin
          if (fmt_byte == cafmt_pkg::CH_PCT) begin
            escape_phase_next = cafmt_pkg::PH_PCT;
          end else begin
            emit_byte = 1'b1;
          end
        end
      end
      cafmt_pkg::PH_PCT: begin
        escape_phase_next = cafmt_pkg::PH_PLAIN;
        case (fmt_byte)
          cafmt_pkg::CH_I: begin
            arg_a_next = a_eff + 16'd1;
            arg_b_next = b_eff + 16'd1;
          end
          cafmt_pkg::CH_D: begin
            emit_dec  = 1'b1;
            turn_next = ~t_eff;
          end
          cafmt_pkg::CH_TWO: begin
            emit_dec  = 1'b1;
            min_w     = 2'd2;
            turn_next = ~t_eff;
          end
          cafmt_pkg::CH_THREE: begin
            emit_dec  = 1'b1;
            min_w     = 2'd3;
            turn_next = ~t_eff;
          end
          cafmt_pkg::CH_DOT: begin
            emit_byte = 1'b1;
            byte_val  = cur[7:0];
            turn_next = ~t_eff;
          end
          cafmt_pkg::CH_PLUS: escape_phase_next = cafmt_pkg::PH_PLUS;
          cafmt_pkg::CH_R: begin
            arg_a_next = b_eff;
            arg_b_next = a_eff;
          end
          cafmt_pkg::CH_PCT: begin
            emit_byte = 1'b1;
            byte_val  = cafmt_pkg::CH_PCT;
          end
          default: ;
        endcase
      end
      default: begin
        escape_phase_next = cafmt_pkg::PH_PLAIN;
        emit_byte = 1'b1;
        byte_val  = cur[7:0] + fmt_byte;
        turn_next = ~t_eff;
      end
    endcase

    n_dig = dec_len(cur);
    n_out = (n_dig < {1'b0, min_w}) ? {1'b0, min_w} : n_dig;

    if (emit_byte) begin
      emitted_count_next = c_eff + 9'd1;
    end else if (emit_dec) begin
      emitted_count_next = c_eff + {6'd0, n_out};
    end

    if (last) begin
      escape_phase_next = cafmt_pkg::PH_PLAIN;
    end

    job_en     = emit_byte | emit_dec | last;
    job.kind   = emit_dec ? cafmt_pkg::JOB_DEC :
                 (emit_byte ? cafmt_pkg::JOB_BYTE : cafmt_pkg::JOB_MARK);
    job.value  = emit_dec ? cur : {8'd0, byte_val};
    job.pos    = emit_dec ? (n_out - 3'd1) : 3'd0;
    job.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_a         <= '0;
      arg_b         <= '0;
      turn          <= 1'b0;
      escape_phase  <= cafmt_pkg::PH_PLAIN;
      emitted_count <= '0;
    end else if (accept) begin
      arg_a         <= arg_a_next;
      arg_b         <= arg_b_next;
      turn          <= turn_next;
      escape_phase  <= escape_phase_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

// ===== sv/cafmt_ser.sv =====
// Result register and serialiser: one output transaction per byte, digit or end marker.
module cafmt_ser (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            job_en,
  input  cafmt_pkg::job_t job,
  input  logic            out_stall,
  output logic            ready,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            string_end
);

  logic            busy;
  cafmt_pkg::job_t cur;
  logic [16:0]     pw;
  logic [3:0]      digit;
  logic [16:0]     dp;
  logic [15:0]     rem;
  logic            fin;
  logic            out_acc;

  always_comb begin
    unique case (cur.pos)
      3'd0:    pw = 17'd1;
      3'd1:    pw = 17'd10;
      3'd2:    pw = 17'd100;
      3'd3:    pw = 17'd1000;
      default: pw = 17'd10000;
    endcase
    // The remaining value is below ten times pw, so the digit is found by
    // nine parallel compares against its multiples.
    digit = 4'd0;
    dp    = 17'd0;
    for (int j = 1; j <= 9; j++) begin
      if ({1'b0, cur.value} >= 17'(j) * pw) begin
        digit = 4'(j);
        dp    = 17'(17'(j) * pw);
      end
    end
    rem = 16'({1'b0, cur.value} - dp);
  end

  assign fin     = (cur.kind != cafmt_pkg::JOB_DEC) || (cur.pos == 3'd0);
  assign out_acc = busy && !out_stall;
  assign ready   = !busy || (!out_stall && fin);

  assign out_valid  = busy;
  assign byte_valid = (cur.kind != cafmt_pkg::JOB_MARK);
  assign run_last   = fin;
  assign string_end = fin && cur.last;

  always_comb begin
    case (cur.kind)
      cafmt_pkg::JOB_DEC:  out_byte = cafmt_pkg::CH_ZERO + {4'd0, digit};
      cafmt_pkg::JOB_BYTE: out_byte = cur.value[7:0];
      default:             out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= job_en;
    end else if (out_acc && fin) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end else if (out_acc && !fin) begin
      cur.value <= rem;
      cur.pos   <= cur.pos - 3'd1;
    end
  end

endmodule

// ===== sv/cafmt_chk.sv =====
// Port-level checker for the cursor-addressing string formatter, with its bind.
module cafmt_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       run_last,
  input logic       string_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_byte) && $stable(byte_valid) &&
                               $stable(run_last) && $stable(string_end))
    else $error("stalled output payload changed");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("template end flagged on a result that is not final for its byte");

  a_marker_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> string_end && out_byte == 8'd0)
    else $error("marker transaction away from the template end");

  a_stall_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> in_stall)
    else $error("input taken while a digit run is still draining");

endmodule

bind cursor_address_string_formatter cafmt_chk u_cafmt_chk (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .run_last   (run_last),
  .string_end (string_end)
);
